// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the binary 3x3 convolution block.
// Depends on nothing; the including module must declare clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define BC3_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, clocked on clk, off while in reset.
`define BC3_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== design/bc3_pkg.sv =====
// Shared constants, types and the popcount function of the binary 3x3 convolution.
// No dependencies.
package bc3_pkg;

	localparam int WORD_BITS  = 64;
	localparam int CH_BITS    = 256;
	localparam int TAPS       = 9;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 10;
	localparam int CFG_W      = 11;
	localparam int PWID_W     = 7;
	localparam int CNT_W      = 9;
	localparam int TOT_W      = 12;
	localparam int SUM_W      = 13;

	// item kinds
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_LOAD  = 1'b1;

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [CH_BITS-1:0] chan_t;
	typedef logic [CNT_W-1:0] tap_cnt_t;
	typedef logic [TAPS-1:0][CNT_W-1:0] tap_cnts_t;

	typedef struct packed {
		logic             valid;
		logic             pixel;
		logic             load;
		logic [3:0]       tap;
		logic             emit;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pipe_ctrl_t;

	// popcount of one 256-bit word as a balanced tree
	function automatic tap_cnt_t pop256(input chan_t v);
		logic [3:0] l0 [32];
		logic [4:0] l1 [16];
		logic [5:0] l2 [8];
		logic [6:0] l3 [4];
		logic [7:0] l4 [2];
		for (int i = 0; i < 32; i++) begin
			l0[i] = '0;
			for (int j = 0; j < 8; j++) begin
				l0[i] = l0[i] + 4'(v[i*8+j]);
			end
		end
		for (int i = 0; i < 16; i++) l1[i] = {1'b0, l0[2*i]} + {1'b0, l0[2*i+1]};
		for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

endpackage

// ===== design/bc3_line_buf.sv =====
// Two line stores of the convolution in two 64-deep RAM banks that swap older and newer line per column.
// Depends on bc3_pkg.
module bc3_line_buf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [bc3_pkg::COL_W-1:0] col,
	input  bc3_pkg::chan_t          px,
	output bc3_pkg::chan_t          line0,
	output bc3_pkg::chan_t          line1
);
	import bc3_pkg::*;

	chan_t      mem0 [MAX_WIDTH];
	chan_t      mem1 [MAX_WIDTH];
	chan_t      rd0_q;
	chan_t      rd1_q;
	// per column: which bank holds the newer line, and how many lines are filled
	logic       newest_q [MAX_WIDTH];
	logic [1:0] fill_q [MAX_WIDTH];
	logic       sel_q;
	logic [1:0] fill_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				newest_q[i] <= 1'b0;
				fill_q[i]   <= 2'd0;
			end
			sel_q     <= 1'b0;
			fill_rd_q <= 2'd0;
		end else if (wr_en) begin
			sel_q          <= newest_q[col];
			fill_rd_q      <= fill_q[col];
			newest_q[col]  <= ~newest_q[col];
			fill_q[col]    <= (fill_q[col] == 2'd2) ? 2'd2 : fill_q[col] + 2'd1;
		end
	end

	// read-before-write: the read returns the lines as they stood before this pixel
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd0_q <= mem0[col];
			rd1_q <= mem1[col];
			if (newest_q[col]) begin
				mem0[col] <= px;
			end else begin
				mem1[col] <= px;
			end
		end
	end

	// unfilled slots read as zero
	assign line1 = (fill_rd_q != 2'd0) ? (sel_q ? rd1_q : rd0_q) : '0;
	assign line0 = (fill_rd_q == 2'd2) ? (sel_q ? rd0_q : rd1_q) : '0;

endmodule

// ===== design/bc3_window.sv =====
// 3x3 window and weight registers, with the per-tap XOR popcount stage.
// Depends on bc3_pkg.
module bc3_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bc3_pkg::pipe_ctrl_t ctrl_s1,
	input  bc3_pkg::chan_t      px_s1,
	input  bc3_pkg::chan_t      line0,
	input  bc3_pkg::chan_t      line1,
	output bc3_pkg::tap_cnts_t  cnt_s3
);
	import bc3_pkg::*;

	chan_t win_q [TAPS];
	chan_t wgt_q [TAPS];

	// shift left, new column enters on the right (top, middle, bottom)
	always_ff @(posedge clk) begin
		if (en && ctrl_s1.valid && ctrl_s1.pixel) begin
			for (int t = 0; t < 3; t++) begin
				win_q[t*3]   <= win_q[t*3+1];
				win_q[t*3+1] <= win_q[t*3+2];
			end
			win_q[2] <= line0;
			win_q[5] <= line1;
			win_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) wgt_q[i] <= '0;
		end else if (en && ctrl_s1.valid && ctrl_s1.load) begin
			wgt_q[ctrl_s1.tap] <= px_s1;
		end
	end

	// mismatch count per tap; window and weights match the item in stage two
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < TAPS; i++) begin
				cnt_s3[i] <= pop256(win_q[i] ^ wgt_q[i]);
			end
		end
	end

endmodule

// ===== design/binary_conv3x3_xnor_popcount.sv =====
// Binary 3x3 convolution, XNOR/popcount form, one filter, 256 channels.
// From an accepted pixel beat to its result beat: input, window, tap-count and output registers.
// Throughput: one beat per cycle; in_ready drops only while a result is held.
// Reset (arst_n low): counters at zero, weights zero, line stores read as zero,
// padded_width 64, padded_height 1024. No clearing pass is needed.
`include "assert_macros.svh"

module binary_conv3x3_xnor_popcount (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [bc3_pkg::CFG_W-1:0]        cfg_data,
	// input beats
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [3:0]                       tap_index,
	input  logic [bc3_pkg::WORD_BITS-1:0]    word_a,
	input  logic [bc3_pkg::WORD_BITS-1:0]    word_b,
	input  logic [bc3_pkg::WORD_BITS-1:0]    word_c,
	input  logic [bc3_pkg::WORD_BITS-1:0]    word_d,
	// result beats
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [bc3_pkg::SUM_W-1:0] conv_sum,
	output logic [bc3_pkg::ROW_W-1:0]        out_row,
	output logic [bc3_pkg::COL_W-1:0]        out_col
);
	import bc3_pkg::*;

	// Pipeline, all stages advance together on en:
	//   accept : counters step, line store read issued at col_q
	//   s1     : input register, line data ready; window shifts / weight loads
	//   s2     : window holds this pixel's neighbourhood; popcounts per tap
	//   s3     : nine tap counts registered; summed into the output register
	logic        en;
	logic        acc;
	logic        pix_acc;
	chan_t       px;

	logic [PWID_W-1:0] width_q;
	logic [CFG_W-1:0]  height_q;
	logic [PWID_W-1:0] eff_w;
	logic [CFG_W-1:0]  eff_h;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              col_wrap;
	logic              row_wrap;

	pipe_ctrl_t  ctrl_s1;
	pipe_ctrl_t  ctrl_s2;
	pipe_ctrl_t  ctrl_s3;
	chan_t       px_s1;
	chan_t       line0;
	chan_t       line1;
	tap_cnts_t   cnt_s3;

	logic [TOT_W-1:0] p0, p1, p2, p3, q0, q1, total;
	logic [SUM_W-1:0] sum_d;

	logic              out_valid_q;
	logic [SUM_W-1:0]  sum_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;

	// output register free, or being emptied this cycle
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign acc      = in_valid && en;
	assign pix_acc  = acc && (action == ACT_PIXEL);
	assign px       = {word_d, word_c, word_b, word_a};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= PWID_W'(MAX_WIDTH);
			height_q <= CFG_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[PWID_W-1:0];
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// saturate the frame size to its legal range
	assign eff_w = (width_q < PWID_W'(3)) ? PWID_W'(3) :
	               (width_q > PWID_W'(MAX_WIDTH)) ? PWID_W'(MAX_WIDTH) : width_q;
	assign eff_h = (height_q < CFG_W'(3)) ? CFG_W'(3) :
	               (height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_q;

	// a count at or past a lowered limit wraps on its next step
	assign col_wrap = ({1'b0, col_q} + PWID_W'(1)) >= eff_w;
	assign row_wrap = ({1'b0, row_q} + CFG_W'(1)) >= eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line stores: read and write at the current column on each pixel
	bc3_line_buf u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (pix_acc),
		.col    (col_q),
		.px     (px),
		.line0  (line0),
		.line1  (line1)
	);

	// control through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s1.valid <= acc;
			ctrl_s1.pixel <= action == ACT_PIXEL;
			ctrl_s1.load  <= (action == ACT_LOAD) && (tap_index < 4'(TAPS));
			ctrl_s1.tap   <= tap_index;
			// full window only from row 2, column 2 on
			ctrl_s1.emit  <= (action == ACT_PIXEL) && (row_q >= ROW_W'(2))
			                 && (col_q >= COL_W'(2));
			ctrl_s1.row   <= row_q - ROW_W'(2);
			ctrl_s1.col   <= col_q - COL_W'(2);
			ctrl_s2       <= ctrl_s1;
			ctrl_s3       <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px;
		end
	end

	bc3_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctrl_s1 (ctrl_s1),
		.px_s1   (px_s1),
		.line0   (line0),
		.line1   (line1),
		.cnt_s3  (cnt_s3)
	);

	// total mismatches over the nine taps
	always_comb begin
		p0    = TOT_W'(cnt_s3[0]) + TOT_W'(cnt_s3[1]);
		p1    = TOT_W'(cnt_s3[2]) + TOT_W'(cnt_s3[3]);
		p2    = TOT_W'(cnt_s3[4]) + TOT_W'(cnt_s3[5]);
		p3    = TOT_W'(cnt_s3[6]) + TOT_W'(cnt_s3[7]);
		q0    = p0 + p1;
		q1    = p2 + p3;
		total = q0 + q1 + TOT_W'(cnt_s3[8]);
		// sum of (256 - 2*mismatch) over nine taps, modulo 2^13
		sum_d = SUM_W'(TAPS * CH_BITS) - {total, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_s3.valid && ctrl_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_q     <= sum_d;
			out_row_q <= ctrl_s3.row;
			out_col_q <= ctrl_s3.col;
		end
	end

	assign out_valid = out_valid_q;
	assign conv_sum  = $signed(sum_q);
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;

	// checks
	`BC3_ASSERT_NXT(a_col_step, pix_acc && !col_wrap, col_q == $past(col_q) + COL_W'(1))
	`BC3_ASSERT_NXT(a_col_wrap, pix_acc && col_wrap, col_q == '0)
	`BC3_ASSERT_IMP(a_sum_range, out_valid_q,
		(sum_q[0] == 1'b0) && ($signed(sum_q) <= 13'sd2304) && ($signed(sum_q) >= -13'sd2304))
	`BC3_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(ctrl_s3.valid && ctrl_s3.emit))

endmodule

// ===== dv/bc3_conv_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the binary 3x3 convolution: watches the config port and both
// channels, keeps its own window model and compares every result beat.
// Depends on bc3_pkg for widths, item kinds and register indexes.
module bc3_conv_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [bc3_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              action,
	input  logic [3:0]                        tap_index,
	input  logic [bc3_pkg::WORD_BITS-1:0]     word_a,
	input  logic [bc3_pkg::WORD_BITS-1:0]     word_b,
	input  logic [bc3_pkg::WORD_BITS-1:0]     word_c,
	input  logic [bc3_pkg::WORD_BITS-1:0]     word_d,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [bc3_pkg::SUM_W-1:0]  conv_sum,
	input  logic [bc3_pkg::ROW_W-1:0]         out_row,
	input  logic [bc3_pkg::COL_W-1:0]         out_col,
	output int                                mismatches,
	output int                                sums_in_flight
);
	import bc3_pkg::*;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
	} conv_res_t;

	conv_res_t         pending_sums [$];
	chan_t             tap_weight [TAPS];
	chan_t             line_top [MAX_WIDTH];
	chan_t             line_mid [MAX_WIDTH];
	chan_t             window_px [TAPS];
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [PWID_W-1:0] width_reg;
	logic [CFG_W-1:0]  height_reg;
	int                fails;

	// shift the window one column left, pull in the new column, score it
	task automatic slide_and_score(input chan_t px);
		int unsigned c;
		int unsigned r;
		int unsigned w;
		int unsigned h;
		int          acc;
		c = col_pos % MAX_WIDTH;
		r = row_pos % MAX_HEIGHT;
		for (int t = 0; t < 3; t++) begin
			window_px[t*3]   = window_px[t*3+1];
			window_px[t*3+1] = window_px[t*3+2];
		end
		window_px[2] = line_top[c];
		window_px[5] = line_mid[c];
		window_px[8] = px;
		line_top[c]  = line_mid[c];
		line_mid[c]  = px;
		if (r >= 2 && c >= 2) begin
			acc = 0;
			for (int t = 0; t < TAPS; t++)
				acc += CH_BITS - 2 * $countones(window_px[t] ^ tap_weight[t]);
			pending_sums.push_back('{sum: SUM_W'(acc), row: ROW_W'(r - 2),
				col: COL_W'(c - 2)});
		end
		w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		conv_res_t got;
		if (!arst_n) begin
			pending_sums.delete();
			for (int i = 0; i < TAPS; i++) begin
				tap_weight[i] = '0;
				window_px[i]  = '0;
			end
			for (int i = 0; i < MAX_WIDTH; i++) begin
				line_top[i] = '0;
				line_mid[i] = '0;
			end
			col_pos        = 0;
			row_pos        = 0;
			width_reg      = PWID_W'(MAX_WIDTH);
			height_reg     = CFG_W'(MAX_HEIGHT);
			fails          = 0;
			mismatches     <= 0;
			sums_in_flight <= 0;
		end else begin
			// results first: a beat accepted on this edge cannot yet have a result
			if (out_valid && out_ready) begin
				if (pending_sums.size() == 0) begin
					$error("result beat with no sum pending: conv_sum %0d row %0d col %0d",
						conv_sum, out_row, out_col);
					fails++;
				end else begin
					got = pending_sums.pop_front();
					if (got.sum !== conv_sum) begin
						$error("conv_sum: expected %0d, actual %0d", got.sum, conv_sum);
						fails++;
					end
					if (got.row !== out_row) begin
						$error("out_row: expected %0d, actual %0d", got.row, out_row);
						fails++;
					end
					if (got.col !== out_col) begin
						$error("out_col: expected %0d, actual %0d", got.col, out_col);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data[PWID_W-1:0];
				else if (cfg_index == REG_HEIGHT)
					height_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (action == ACT_LOAD) begin
					if (tap_index < TAPS)
						tap_weight[tap_index] = {word_d, word_c, word_b, word_a};
				end else begin
					slide_and_score({word_d, word_c, word_b, word_a});
				end
			end
			sums_in_flight <= pending_sums.size();
			mismatches     <= fails;
		end
	end

endmodule

// ===== dv/tb_binary_conv3x3_xnor_popcount.sv =====
`timescale 1ns / 1ps
// Top of the binary 3x3 convolution testbench: clock, reset, stimulus and verdict.
// Depends on bc3_pkg, the block itself and bc3_conv_checker.
module tb_binary_conv3x3_xnor_popcount;
	import bc3_pkg::*;

	// settle margin that lets the pipe empty
	localparam int SETTLE = 8;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic                    cfg_index = REG_WIDTH;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    action = ACT_PIXEL;
	logic [3:0]              tap_index = '0;
	logic [WORD_BITS-1:0]    word_a = '0;
	logic [WORD_BITS-1:0]    word_b = '0;
	logic [WORD_BITS-1:0]    word_c = '0;
	logic [WORD_BITS-1:0]    word_d = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [SUM_W-1:0] conv_sum;
	logic [ROW_W-1:0]        out_row;
	logic [COL_W-1:0]        out_col;

	int    mismatches;
	int    sums_in_flight;
	int    idle_pct = 0;    // chance per cycle that the sender holds off
	int    stall_pct = 0;   // chance per cycle that the receiver stalls
	chan_t tap_shadow [TAPS];  // last filter loaded, used to aim pixels near it

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	binary_conv3x3_xnor_popcount u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.tap_index (tap_index),
		.word_a    (word_a),
		.word_b    (word_b),
		.word_c    (word_c),
		.word_d    (word_d),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.conv_sum  (conv_sum),
		.out_row   (out_row),
		.out_col   (out_col)
	);

	bc3_conv_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.tap_index      (tap_index),
		.word_a         (word_a),
		.word_b         (word_b),
		.word_c         (word_c),
		.word_d         (word_d),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.conv_sum       (conv_sum),
		.out_row        (out_row),
		.out_col        (out_col),
		.mismatches     (mismatches),
		.sums_in_flight (sums_in_flight)
	);

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("tb_binary_conv3x3_xnor_popcount NOT OK");
		$finish;
	end

	// Drive one beat and hold it until accepted. Valid is only dropped when an
	// idle gap is drawn, so back-to-back beats keep valid high throughout.
	task automatic push_beat(input logic act, input logic [3:0] tap, input chan_t data);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		tap_index <= tap;
		word_a    <= data[63:0];
		word_b    <= data[127:64];
		word_c    <= data[191:128];
		word_d    <= data[255:192];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop sending until every pending sum is out, then let the pipe empty.
	// Pixels in the first rows give no result, so the margin covers those too.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sums_in_flight != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both registers written back to back while the block is quiet
	task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic chan_t rand_chan();
		return {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Pixel content: mostly random, with solid words and near or inverted copies
	// of a loaded tap so that sums reach towards both ends of the range.
	function automatic chan_t pick_pixel();
		chan_t       v;
		int unsigned k;
		k = $urandom_range(9);
		v = rand_chan();
		if (k == 0)
			v = '0;
		else if (k == 1)
			v = '1;
		else if (k == 2) begin
			v = tap_shadow[$urandom_range(TAPS - 1)];
			v[$urandom_range(CH_BITS - 1)] ^= 1'b1;
		end else if (k == 3)
			v = ~tap_shadow[$urandom_range(TAPS - 1)];
		return v;
	endfunction

	function automatic chan_t pick_weight();
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		return rand_chan();
	endfunction

	// One random phase: mostly pixel beats, some tap loads, a few loads past
	// the last tap that the block must ignore (these are not counted).
	task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int send_idle, input int recv_stall, input int n_beats);
		int          sent;
		int unsigned roll;
		logic [3:0]  tap;
		chan_t       data;
		set_geometry(w, h);
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		sent      = 0;
		while (sent < n_beats) begin
			// now and then hold off until nothing is pending
			if ($urandom_range(199) == 0)
				drain();
			roll = $urandom_range(99);
			if (roll < 8) begin
				tap  = 4'($urandom_range(TAPS - 1));
				data = pick_weight();
				tap_shadow[tap] = data;
				push_beat(ACT_LOAD, tap, data);
				sent++;
			end else if (roll < 10) begin
				push_beat(ACT_LOAD, 4'($urandom_range(15, TAPS)), rand_chan());
			end else begin
				push_beat(ACT_PIXEL, 4'($urandom), pick_pixel());
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		for (int i = 0; i < TAPS; i++)
			tap_shadow[i] = '0;

		// single reset at the start
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, 3x3 frames: one result per frame ----
		set_geometry(3, 3);
		// zero frame against the zero reset filter: every channel matches
		repeat (9) push_beat(ACT_PIXEL, 4'd0, '0);
		// loads past the last tap must leave the filter untouched
		push_beat(ACT_LOAD, 4'd9, '1);
		push_beat(ACT_LOAD, 4'd15, '1);
		// all-ones frame: every channel mismatches, unless a bad load got in
		repeat (9) push_beat(ACT_PIXEL, 4'hF, '1);
		// first and last taps
		push_beat(ACT_LOAD, 4'd0, '1);
		tap_shadow[0] = '1;
		push_beat(ACT_LOAD, 4'd8, {4{64'hAAAA_AAAA_AAAA_AAAA}});
		tap_shadow[8] = {4{64'hAAAA_AAAA_AAAA_AAAA}};
		// start of the next frame with alternating patterns
		push_beat(ACT_PIXEL, 4'd8, {4{64'h5555_5555_5555_5555}});
		push_beat(ACT_PIXEL, 4'd0, {4{64'hAAAA_AAAA_AAAA_AAAA}});
		push_beat(ACT_PIXEL, 4'hF, '1);

		// ---- random phases: geometry, sender idling, receiver stalls ----
		// widest row, shortest frame, no idling at all
		run_phase(64, 3, 0, 0, 140);
		// height below range saturates to 3, sender mostly idle
		run_phase(5, 0, 83, 0, 130);
		// width above range saturates to 64, receiver mostly stalled
		run_phase(127, 6, 0, 83, 130);
		// width below range, tallest frame, both sides idling
		run_phase(0, 1024, 33, 33, 130);
		// mid-frame change: counters carry over, height saturates to 1024
		run_phase(17, 2047, 0, 0, 100);
		// random geometry: any legal width, height up to 12
		run_phase(CFG_W'($urandom_range(MAX_WIDTH, 3)), CFG_W'($urandom_range(12, 3)),
			33, 33, 130);

		// ---- wind down and give the verdict ----
		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("tb_binary_conv3x3_xnor_popcount OK");
		else
			$display("tb_binary_conv3x3_xnor_popcount NOT OK");
		$finish;
	end

endmodule
